>>> src/ils_pkg.sv
package ils_pkg;

  // List geometry.
  localparam int unsigned Depth     = 16;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  // Compare width covers the count, the five-bit position and one carry bit.
  localparam int unsigned CmpW      = ((CntW > 5) ? CntW : 5) + 1;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [CmpW-1:0]      cmp_t;

  // Operation codes of the command transaction.
  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_POP_LAST = 3'd2,
    OP_POP_FRST = 3'd3,
    OP_PEEK_LST = 3'd4,
    OP_PEEK_AT  = 3'd5,
    OP_REMOVE   = 3'd6,
    OP_REPLACE  = 3'd7
  } op_e;

  // Error codes of the result transaction.
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_FULL  = 2'd3
  } err_e;

  // Per-cell action for one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  position;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    err_e        error_code;
    logic [4:0]  entry_count;
  } res_t;

  // Keep the low bits of a 32-bit command word as a list word.
  function automatic word_t to_word(logic [31:0] v);
    word_t w;
    for (int i = 0; i < WordWidth; i++) begin
      w[i] = (i < 32) ? v[i] : 1'b0;
    end
    return w;
  endfunction

  // Zero-extend or truncate a list word to the 32-bit result field.
  function automatic logic [31:0] from_word(word_t w);
    logic [31:0] v;
    for (int i = 0; i < 32; i++) begin
      v[i] = (i < WordWidth) ? w[i] : 1'b0;
    end
    return v;
  endfunction

endpackage

>>> src/ils_cell.sv
module ils_cell
  import ils_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_e cmd_i,
  input  word_t     load_i,
  input  word_t     below_i,
  input  word_t     above_i,
  output word_t     word_o
);

  word_t word_q, word_d;

  // Pick the new content: hold, take the command word, or take a neighbor's word.
  always_comb begin
    case (cmd_i)
      CELL_HOLD: word_d = word_q;
      CELL_LOAD: word_d = load_i;
      CELL_UP:   word_d = below_i;
      CELL_DOWN: word_d = above_i;
      default:   word_d = word_q;
    endcase
  end

  // Entry storage carries no reset; it is read only after it was written.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> src/indexed_list_store_top.sv
// Result: a command's result is registered and shown, with result_valid_o
// high, in the cycle after the command was accepted.
// Throughput: one command per cycle; every cell of the chain shifts at once,
// so busy_o stays low and the receiver cannot stall.
// Reset: rst_ni clears the entry count and the result strobe asynchronously;
// entry words are not cleared and are only read after being written.
module indexed_list_store_top
  import ils_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic result_valid_o,
  output res_t result_o
);

  cnt_t      count_q, count_d;
  logic      valid_q;
  res_t      res_q, res_d;
  word_t     cell_words [Depth];
  cell_cmd_e cell_cmds  [Depth];
  logic      accept;
  err_e      err;
  cmp_t      cnt_ext, pos_ext, pidx, rd_sel;
  word_t     new_word;
  logic      do_append, do_insert, do_shift_dn, do_replace;

  // The chain completes any command in the accept cycle.
  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign cnt_ext  = CmpW'(count_q);
  assign pos_ext  = CmpW'(cmd_i.position);
  assign pidx     = pos_ext - CmpW'(1);
  assign new_word = to_word(cmd_i.value);

  // Decode the command: error check, read index and new count.
  always_comb begin
    err         = ERR_OK;
    rd_sel      = pidx;
    count_d     = count_q;
    do_append   = 1'b0;
    do_insert   = 1'b0;
    do_shift_dn = 1'b0;
    do_replace  = 1'b0;
    case (cmd_i.op)
      OP_APPEND: begin
        if (count_q == CntW'(Depth)) begin
          err = ERR_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
          err = ERR_RANGE;
        end else if (count_q == CntW'(Depth)) begin
          err = ERR_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end
      OP_POP_LAST: begin
        rd_sel = cnt_ext - CmpW'(1);
        if (count_q == '0) begin
          err = ERR_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      OP_POP_FRST: begin
        rd_sel = '0;
        if (count_q == '0) begin
          err = ERR_EMPTY;
        end else begin
          do_shift_dn = 1'b1;
          count_d     = count_q - CntW'(1);
        end
      end
      OP_PEEK_LST: begin
        rd_sel = cnt_ext - CmpW'(1);
        if (count_q == '0) begin
          err = ERR_EMPTY;
        end
      end
      OP_PEEK_AT, OP_REMOVE, OP_REPLACE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          err = ERR_RANGE;
        end else if (cmd_i.op == OP_REMOVE) begin
          do_shift_dn = 1'b1;
          count_d     = count_q - CntW'(1);
        end else if (cmd_i.op == OP_REPLACE) begin
          do_replace = 1'b1;
        end
      end
      default: begin
        err = ERR_OK;
      end
    endcase
  end

  // Per-cell action; the shift origin is pidx for insert and remove, zero for pop first.
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      cell_cmds[k] = CELL_HOLD;
      if (accept) begin
        if (do_append && CmpW'(k) == cnt_ext) begin
          cell_cmds[k] = CELL_LOAD;
        end else if (do_insert && CmpW'(k) == pidx) begin
          cell_cmds[k] = CELL_LOAD;
        end else if (do_insert && CmpW'(k) > pidx && CmpW'(k) <= cnt_ext) begin
          cell_cmds[k] = CELL_UP;
        end else if (do_shift_dn && CmpW'(k) >= rd_sel) begin
          cell_cmds[k] = CELL_DOWN;
        end else if (do_replace && CmpW'(k) == pidx) begin
          cell_cmds[k] = CELL_LOAD;
        end
      end
    end
  end

  // The chain of entry cells, each wired to its neighbors.
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    word_t below_w, above_w;
    if (k == 0) begin : g_first
      assign below_w = '0;
    end else begin : g_mid_lo
      assign below_w = cell_words[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign above_w = '0;
    end else begin : g_mid_hi
      assign above_w = cell_words[k+1];
    end
    ils_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmds[k]),
      .load_i  (new_word),
      .below_i (below_w),
      .above_i (above_w),
      .word_o  (cell_words[k])
    );
  end

  // Result word: the old entry on success of a reading command, zero otherwise.
  always_comb begin
    res_d.read_value  = '0;
    res_d.error_code  = err;
    res_d.entry_count = CmpW'(count_d) >> 0 == '0 ? 5'd0 : 5'(CmpW'(count_d));
    if (err == ERR_OK && cmd_i.op != OP_APPEND && cmd_i.op != OP_INSERT) begin
      res_d.read_value = from_word(cell_words[rd_sel[IdxW-1:0]]);
    end
  end

  // Control state: entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds depth");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted command gave no result");

  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without a command");

  a_err_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && err != ERR_OK |=> count_q == $past(count_q))
    else $error("failed command changed the list");

  a_count_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.entry_count == 5'(CmpW'(count_q)))
    else $error("reported count differs from held count");
`endif

endmodule
